### design/fim_pkg.sv
// shared types and constants of the frame interval monitor
package fim_pkg;

	localparam int TS_W   = 48;
	localparam int FREQ_W = 32;
	localparam int SMP_W  = 32;
	localparam int RATE_W = 16;
	localparam int HELD_W = 6;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
	localparam logic [RATE_W-1:0] RATE_MAX   = 16'hFFFF;
	localparam logic [SMP_W-1:0]  SMP_MAX    = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_REBASE = 2'd1,
		OP_RESUME = 2'd2,
		OP_PAUSE  = 2'd3
	} op_e_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [TS_W-1:0] timestamp;
	} item_t;

	typedef struct packed {
		logic [RATE_W-1:0] frame_rate;
		logic [SMP_W-1:0]  avg_frame_ticks;
		logic [TS_W-1:0]   total_ticks;
		logic [HELD_W-1:0] samples_held;
		logic              paused;
	} result_t;

	typedef struct packed {
		op_e_t           op;
		logic [TS_W-1:0] timestamp;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GATE,
		ST_FRAME,
		ST_SUM,
		ST_DIV,
		ST_WAIT,
		ST_TOTAL,
		ST_PUSH
	} bk_state_t;

endpackage

### design/frame_interval_monitor_unit.sv
// top level of the frame interval monitor: config register, front end and back end
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ----------------------------------
//  input     in         push / full          item: op, timestamp
//  result    out        pop / empty          result: rate, avg, total, held, paused
//  config    in         cfg_wr_en            cfg_wr_data: counter ticks per second
//
// a tick runs the exec, gate, frame, sum, div, wait, total and push states in the
// back end; the bit-serial divider for the window mean runs in wait on SUM_W bits
// (SUM_W = 32 + clog2(WINDOW+1), so 38 at WINDOW = 50); an empty window skips it
// control words (rebase, resume, pause) run only the exec, total and push states
// the front end buffers two words, so input is taken while the back end works
// the result queue holds two words; the back end waits only when it is full
// reset is asynchronous and brings all counters to zero, the frequency to 10e6;
// window memory contents are not cleared, entries are read only once written
module frame_interval_monitor_unit #(
	parameter int WINDOW = 50
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  fim_pkg::item_t             item,
	output logic                       empty,
	input  logic                       pop,
	output fim_pkg::result_t           result,
	input  logic                       cfg_wr_en,
	input  logic [fim_pkg::FREQ_W-1:0] cfg_wr_data
);
	import fim_pkg::*;

	logic [FREQ_W-1:0] freq_q;
	logic              cmd_valid;
	logic              cmd_take;
	cmd_t              cmd;

	// counter frequency, the one-second threshold for gating and rate counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			freq_q <= FREQ_RESET;
		else if (cfg_wr_en)
			freq_q <= cfg_wr_data;
	end

	// front end: takes input words and decodes them into commands
	fim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	// back end: runs each command and queues one result word for it
	fim_back #(.WINDOW(WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.freq      (freq_q),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

### design/fim_front.sv
// front end: accepts input words, decodes the op, buffers commands for the back end
module fim_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  fim_pkg::item_t item,
	output logic           cmd_valid,
	input  logic           cmd_take,
	output fim_pkg::cmd_t  cmd
);
	import fim_pkg::*;

	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	cmd_t       slot_q [2];
	cmd_t       new_cmd;
	logic       accept;

	// decode the raw op field into a command
	always_comb begin
		new_cmd.op        = op_e_t'(item.op);
		new_cmd.timestamp = item.timestamp;
	end

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (accept)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_take)
				rd_ptr_q <= !rd_ptr_q;
			case ({accept, cmd_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			slot_q[wr_ptr_q] <= new_cmd;
	end

endmodule

### design/fim_div.sv
// restoring divider, one quotient bit per cycle
module fim_div #(
	parameter int DVD_W = 38,
	parameter int DVS_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

### design/fim_back.sv
// back end: time accounting, interval window, frame counter and result queue
module fim_back #(
	parameter int WINDOW = 50
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fim_pkg::FREQ_W-1:0]    freq,
	input  logic                          cmd_valid,
	output logic                          cmd_take,
	input  fim_pkg::cmd_t                 cmd,
	output logic                          empty,
	input  logic                          pop,
	output fim_pkg::result_t              result
);
	import fim_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = SMP_W + CNT_W;

	bk_state_t state_q, state_d;

	// architectural state
	logic [TS_W-1:0]   last_q, cur_q, base_q, stop_q, paused_tot_q;
	logic              stopped_q;
	logic [CNT_W-1:0]  held_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SMP_W-1:0]  avg_q;
	logic [RATE_W-1:0] frames_q, rate_q;
	logic [FREQ_W-1:0] accum_q;
	logic [PTR_W-1:0]  wr_ptr_q;

	// per-command working registers
	cmd_t              cmd_q;
	logic [TS_W-1:0]   interval_q, diff_q, run_tot_q;
	logic              accept_q;
	logic [SMP_W-1:0]  sat_q, old_q;

	logic [SMP_W-1:0]  win_mem [WINDOW];

	logic              mem_we, div_start, div_done, out_push;
	logic [SUM_W-1:0]  quo;
	logic [TS_W:0]     accum_sum;
	logic [RATE_W-1:0] frames_inc;
	logic              win_full;
	logic [CNT_W+HELD_W-1:0] held_wide;
	logic [TS_W-1:0]   avg_ext;

	// result queue
	logic [1:0] out_cnt_q;
	logic       out_wr_q, out_rd_q;
	result_t    out_slot_q [2];
	result_t    new_res;
	logic       out_pop;

	assign win_full   = (held_q == CNT_W'(WINDOW));
	assign accum_sum  = {(TS_W + 1 - FREQ_W)'(0), accum_q} + {1'b0, interval_q};
	assign frames_inc = (frames_q == RATE_MAX) ? RATE_MAX : frames_q + 1'b1;
	assign held_wide  = {HELD_W'(0), held_q};
	assign avg_ext    = {(TS_W - SMP_W)'(0), avg_q};

	fim_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_take  = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_push  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_cnt_q != 2'd2) begin
					cmd_take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC:  state_d = (cmd_q.op == OP_TICK) ? ST_GATE : ST_TOTAL;
			ST_GATE:  state_d = ST_FRAME;
			ST_FRAME: state_d = ST_SUM;
			ST_SUM: begin
				mem_we  = accept_q;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (held_q == '0) begin
					state_d = ST_TOTAL;
				end else begin
					div_start = 1'b1;
					state_d   = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (div_done)
					state_d = ST_TOTAL;
			end
			ST_TOTAL: state_d = ST_PUSH;
			ST_PUSH: begin
				out_push = 1'b1;
				state_d  = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= '0;
			cur_q        <= '0;
			base_q       <= '0;
			stop_q       <= '0;
			paused_tot_q <= '0;
			stopped_q    <= 1'b0;
			held_q       <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			frames_q     <= '0;
			rate_q       <= '0;
			accum_q      <= '0;
			wr_ptr_q     <= '0;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					unique case (cmd_q.op)
						OP_TICK: begin
							last_q <= cmd_q.timestamp;
							cur_q  <= cmd_q.timestamp;
						end
						OP_REBASE: begin
							base_q       <= cmd_q.timestamp;
							last_q       <= cmd_q.timestamp;
							stop_q       <= '0;
							stopped_q    <= 1'b0;
							paused_tot_q <= '0;
						end
						OP_RESUME: begin
							if (stopped_q) begin
								paused_tot_q <= paused_tot_q + (cmd_q.timestamp - stop_q);
								last_q       <= cmd_q.timestamp;
								stop_q       <= '0;
								stopped_q    <= 1'b0;
							end
						end
						OP_PAUSE: begin
							if (!stopped_q) begin
								stop_q    <= cmd_q.timestamp;
								stopped_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_FRAME: begin
					if (accum_sum > {(TS_W + 1 - FREQ_W)'(0), freq}) begin
						rate_q   <= frames_inc;
						frames_q <= '0;
						accum_q  <= '0;
					end else begin
						frames_q <= frames_inc;
						accum_q  <= accum_sum[FREQ_W-1:0];
					end
				end
				ST_SUM: begin
					if (accept_q) begin
						sum_q <= sum_q + SUM_W'(sat_q) - (win_full ? SUM_W'(old_q) : '0);
						if (!win_full)
							held_q <= held_q + 1'b1;
						wr_ptr_q <= (wr_ptr_q == PTR_W'(WINDOW - 1)) ? '0 : wr_ptr_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (held_q == '0)
						avg_q <= '0;
				end
				ST_WAIT: begin
					if (div_done)
						avg_q <= quo[SMP_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take)
			cmd_q <= cmd;
		if (state_q == ST_EXEC)
			interval_q <= cmd_q.timestamp - last_q;
		if (state_q == ST_GATE)
			diff_q <= (interval_q >= avg_ext) ? interval_q - avg_ext : avg_ext - interval_q;
		if (state_q == ST_FRAME) begin
			accept_q <= (diff_q < {(TS_W - FREQ_W)'(0), freq});
			sat_q    <= (interval_q[TS_W-1:SMP_W] != '0) ? SMP_MAX : interval_q[SMP_W-1:0];
		end
		if (state_q == ST_TOTAL)
			run_tot_q <= (stopped_q ? stop_q : cur_q) - paused_tot_q;
	end

	// window memory: oldest entry sits at the write pointer
	always_ff @(posedge clk) begin
		if (mem_we)
			win_mem[wr_ptr_q] <= sat_q;
		old_q <= win_mem[wr_ptr_q];
	end

	always_comb begin
		new_res.frame_rate      = rate_q;
		new_res.avg_frame_ticks = avg_q;
		new_res.total_ticks     = run_tot_q - base_q;
		new_res.samples_held    = held_wide[HELD_W-1:0];
		new_res.paused          = stopped_q;
	end

	assign out_pop = pop && !empty;
	assign empty   = (out_cnt_q == 2'd0);
	assign result  = out_slot_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
		end else begin
			if (out_push)
				out_wr_q <= !out_wr_q;
			if (out_pop)
				out_rd_q <= !out_rd_q;
			case ({out_push, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_push)
			out_slot_q[out_wr_q] <= new_res;
	end

`ifndef SYNTHESIS
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_cnt_q != 2'd2)
		else $error("result queue overflow");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside wait state");

	a_empty_window_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && held_q == '0) |-> avg_q == '0)
		else $error("nonzero average with empty window");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && accept_q && win_full) |=> held_q == CNT_W'(WINDOW))
		else $error("sample count moved past window depth");
`endif

endmodule
